// ===== hdl/sss_pkg.sv =====
// Package with shared types and constants for the state-space stepper.
`timescale 1ns / 1ps
package sss_pkg;
  localparam int MaxOrder = 8;
  localparam int FracBits = 16;
  localparam int AccW = 72;

  typedef enum logic [1:0] {
    ACT_COEF   = 2'd0,
    ACT_STATE  = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2,
    SEL_D = 2'd3
  } msel_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

  // Control word that travels along the cell chain.
  typedef struct packed {
    logic rot;     // rotate the state ring by one cell
    logic push;    // shift only the shadow ring by one cell
    logic load;    // load shadow state into the live state
  } cell_ctl_t;
endpackage

// ===== hdl/sss_cell.sv =====
// One cell of the state ring: a state element and its shadow for the next state.
`timescale 1ns / 1ps
module sss_cell (
  input  logic                clk,
  input  sss_pkg::cell_ctl_t  ctl,
  input  logic                wr_x,
  input  logic [31:0]         wr_data,
  input  logic                wr_nx,
  input  logic [31:0]         nx_data,
  input  logic [31:0]         x_prev,
  input  logic [31:0]         nx_prev,
  input  logic                rst,
  output logic [31:0]         x,
  output logic [31:0]         nx
);
  import sss_pkg::*;
  always_ff @(posedge clk) begin
    if (rst) begin
      x  <= '0;
      nx <= '0;
    end else begin
      if (wr_x) x <= wr_data;
      else if (ctl.rot) x <= x_prev;
      else if (ctl.load) x <= nx;
      if (wr_nx) nx <= nx_data;
      else if (ctl.rot || ctl.push) nx <= nx_prev;
    end
  end
endmodule

// ===== hdl/sss_mac.sv =====
// Shared multiply-accumulate with floor shift and 32-bit saturation, and a small generic RAM.
`timescale 1ns / 1ps
module sss_mac #(
  parameter int FRAC_BITS = sss_pkg::FracBits
) (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] res,
  output logic               sat
);
  import sss_pkg::*;
  logic signed [63:0]   prod;
  logic                 pv;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] sh;
  always_ff @(posedge clk) begin
    prod <= a * b;
    pv   <= en;
    if (clr) acc <= '0;
    else if (pv) acc <= acc + AccW'(prod);
  end
  always_comb begin
    sh = acc >>> FRAC_BITS;
    if (sh > AccW'(32'sh7fffffff)) begin
      res = 32'sh7fffffff; sat = 1'b1;
    end else if (sh < -AccW'(64'sh80000000)) begin
      res = 32'sh80000000; sat = 1'b1;
    end else begin
      res = sh[31:0]; sat = 1'b0;
    end
  end
endmodule

// Simple dual-port RAM: one write port, one read port with registered data.
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/state_space_system_stepper.sv =====
// Top level of the discrete state-space stepper.
`timescale 1ns / 1ps
// A sample transfer at order n is worked on as n+1 rows of n+1 products, each row
// followed by a drain of the operand and accumulator stages. Its result is then
// offered from the output state, and the next transfer is taken back in idle, later
// while an earlier result waits. A load transfer is taken while idle. One shared
// multiplier-accumulator sets the rate. Reset (rst, synchronous) clears all
// coefficients (A through its valid bits), the state and the order register (to 1).
module state_space_system_stepper #(
  parameter int MAX_ORDER = sss_pkg::MaxOrder,
  parameter int FRAC_BITS = sss_pkg::FracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // s_tdata from bit 0: action[1:0], matrix_select[3:2], row_index[6:4],
  // col_index[9:7], coef_value[41:10], init_value[73:42], sample_in[105:74], zeros
  input  logic [111:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // m_tdata from bit 0: y_out[31:0]
  output logic [31:0] m_tdata,
  // m_tuser: saturated
  output logic        m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready
);
  import sss_pkg::*;
  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW = $clog2(MAX_ORDER + 2);
  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER*MAX_ORDER) : 1;

  logic [1:0]  act;
  logic [1:0]  msel;
  logic [2:0]  row, col;
  logic [31:0] coef, init, smp;
  assign act  = s_tdata[1:0];
  assign msel = s_tdata[3:2];
  assign row  = s_tdata[6:4];
  assign col  = s_tdata[9:7];
  assign coef = s_tdata[41:10];
  assign init = s_tdata[73:42];
  assign smp  = s_tdata[105:74];

  logic [3:0] order_reg;
  always_ff @(posedge clk) begin
    if (rst) order_reg <= 4'd1;
    else if (cfg_we) order_reg <= cfg_wdata;
  end
  logic [CW-1:0] n_eff;
  always_comb begin
    if (order_reg == 4'd0) n_eff = CW'(1);
    else if (32'(order_reg) > MAX_ORDER) n_eff = CW'(MAX_ORDER);
    else n_eff = CW'(order_reg);
  end

  // B, C and D are small and reset-cleared. A sits in a RAM; an entry that was
  // never written since reset reads as zero through its valid bit.
  logic signed [31:0] b_st [MAX_ORDER];
  logic signed [31:0] c_st [MAX_ORDER];
  logic signed [31:0] d_co;
  logic [MAX_ORDER*MAX_ORDER-1:0] a_vld;
  logic          a_we;
  logic [AW-1:0] a_waddr, a_raddr;
  logic signed [31:0] a_rdata;

  state_t st, st_next;
  logic [CW-1:0] ri, ji;  // ri: 0 is y, r>0 is state row r-1; ji: term index
  logic [2:0]    drain;
  logic signed [31:0] u;
  logic          satf;
  logic [31:0]   y_hold;
  logic          in_ok;
  assign in_ok = s_tvalid && s_tready;
  assign s_tready = (st == ST_IDLE);

  // Cell ring. Cell 0 holds element ji during a row when x rotates by n.
  logic [31:0] xs [MAX_ORDER];
  logic [31:0] nxs [MAX_ORDER];
  cell_ctl_t ctl;
  logic [MAX_ORDER-1:0] wr_x;
  logic nx_we;
  logic [31:0] nx_val;

  // Product operands for step (ri, ji). The A coefficient arrives from the registered
  // RAM read in the cycle after its address, so the other operands are registered to line up with it.
  logic signed [31:0] ma, mb, mo, mb_r, mo_r;
  logic use_a, use_a_r, a_vld_r, en_r;
  logic step_en, mac_clr;
  logic signed [31:0] mres;
  logic msat;
  logic last_term;
  assign last_term = (ji == n_eff);
  always_comb begin
    use_a   = !last_term && (ri != '0);
    a_raddr = AW'(MAX_ORDER*32'(ri - CW'(1)) + 32'(ji));
    if (last_term) begin
      mb = u;
      mo = (ri == '0) ? d_co : b_st[IW'(ri - CW'(1))];
    end else begin
      mb = xs[0];
      mo = c_st[IW'(ji)];
    end
  end
  always_ff @(posedge clk) begin
    mb_r    <= mb;
    mo_r    <= mo;
    use_a_r <= use_a;
    en_r    <= step_en;
    a_vld_r <= a_vld[a_raddr];
  end
  assign ma = use_a_r ? (a_vld_r ? a_rdata : 32'sd0) : mo_r;

  sss_ram #(.WIDTH(32), .DEPTH(MAX_ORDER*MAX_ORDER), .AW(AW)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(coef),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  sss_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .clr(mac_clr), .en(en_r),
    .a(ma), .b(mb_r), .res(mres), .sat(msat)
  );

  // Ring rotation over the first n cells: cell i takes cell i+1, cell n-1 cell 0.
  genvar g;
  generate
    for (g = 0; g < MAX_ORDER; g++) begin : g_cell
      logic [31:0] xp, np;
      always_comb begin
        if (g == n_eff - CW'(1) || g == MAX_ORDER - 1) begin
          xp = xs[0]; np = nxs[0];
        end else begin
          xp = xs[(g+1) % MAX_ORDER]; np = nxs[(g+1) % MAX_ORDER];
        end
      end
      cell_ctl_t cc;
      assign cc.rot  = ctl.rot && (g < n_eff);
      assign cc.push = ctl.push && (g < n_eff);
      assign cc.load = ctl.load && (g < n_eff);
      sss_cell u_cell (
        .clk(clk), .rst(rst), .ctl(cc),
        .wr_x(wr_x[g]), .wr_data(init),
        .wr_nx(nx_we && (g == n_eff - CW'(1))), .nx_data(nx_val),
        .x_prev(xp), .nx_prev(np), .x(xs[g]), .nx(nxs[g])
      );
    end
  endgenerate

  // Row end: after the last term, wait for the operand and accumulator stages.
  // A finished state row enters the shadow ring at cell n-1 while only the
  // shadow ring shifts, so the live state stays aligned for the next row.
  always_comb begin
    st_next  = st;
    step_en  = 1'b0;
    mac_clr  = 1'b0;
    ctl      = '0;
    nx_we    = 1'b0;
    nx_val   = mres;
    case (st)
      ST_IDLE: begin
        mac_clr = 1'b1;
        if (in_ok && act == ACT_SAMPLE) st_next = ST_RUN;
      end
      ST_RUN: begin
        if (drain == 3'd0) begin
          step_en = 1'b1;
          ctl.rot = !last_term;
        end else if (drain == 3'd3) begin
          mac_clr = 1'b1;
          if (ri != '0) begin
            nx_we = 1'b1;
            ctl.push = 1'b1;
          end
          if (ri == n_eff) begin
            st_next = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        ctl.load = !m_tvalid;
        if (!m_tvalid) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE; ri <= '0; ji <= '0; drain <= '0;
      m_tvalid <= 1'b0; satf <= 1'b0;
    end else begin
      st <= st_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (st)
        ST_IDLE: begin
          ri <= '0; ji <= '0; drain <= '0; satf <= 1'b0;
          if (in_ok && act == ACT_SAMPLE) u <= smp;
        end
        ST_RUN: begin
          if (drain == 3'd0) begin
            if (last_term) drain <= 3'd1;
            else ji <= ji + CW'(1);
          end else if (drain == 3'd3) begin
            drain <= '0; ji <= '0; ri <= ri + CW'(1);
            satf <= satf | msat;
            if (ri == '0) y_hold <= mres;
          end else drain <= drain + 3'd1;
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= y_hold;
            m_tuser  <= satf;
          end
        end
        default: ;
      endcase
    end
  end

  // Loads.
  always_comb begin
    wr_x = '0;
    if (in_ok && act == ACT_STATE && 32'(row) < MAX_ORDER)
      wr_x[IW'(row)] = 1'b1;
  end
  assign a_we = in_ok && act == ACT_COEF && msel == SEL_A &&
                32'(row) < MAX_ORDER && 32'(col) < MAX_ORDER;
  assign a_waddr = AW'(MAX_ORDER*32'(row) + 32'(col));
  always_ff @(posedge clk) begin
    if (rst) a_vld <= '0;
    else if (a_we) a_vld[a_waddr] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        b_st[i] <= '0; c_st[i] <= '0;
      end
      d_co <= '0;
    end else if (in_ok && act == ACT_COEF) begin
      case (msel)
        SEL_A: ;
        SEL_B: if (32'(row) < MAX_ORDER) b_st[IW'(row)] <= coef;
        SEL_C: if (32'(col) < MAX_ORDER) c_st[IW'(col)] <= coef;
        SEL_D: d_co <= coef;
        default: ;
      endcase
    end
  end

  // Nothing is accepted while a sample is being worked on.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (st != ST_IDLE) |-> !s_tready) else $error("accepting while busy");
  // A result only appears after the output state.
  a_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(st) == ST_OUT) else $error("stray result");
  // Row counter never passes the order.
  a_row: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RUN) |-> ri <= n_eff) else $error("row overrun");
endmodule
